>>> sv/lgrs_pkg.sv
package lgrs_pkg;

	// grid geometry
	localparam int MAX_COLS = 64;
	localparam int COL_W    = 7;

	// apb register file
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	typedef enum logic {
		REG_COLS_IN_USE = 1'b0
	} reg_idx_t;

	localparam logic [COL_W-1:0] COLS_RESET = COL_W'(MAX_COLS);

	// bits of one column seen by a cell's neighbors
	typedef struct packed {
		logic up;
		logic mid;
		logic dn;
	} col_t;

	// per-word control broadcast to every cell
	typedef struct packed {
		logic shift;
		logic clear;
	} ctrl_t;

	// what an accepted word leaves for the output side
	typedef struct packed {
		logic load;
		logic v0;
		logic v1;
	} load_t;

endpackage

>>> sv/lgrs_if.sv
interface lgrs_in_if;
	import lgrs_pkg::*;

	logic                valid;
	logic                ready;
	logic [MAX_COLS-1:0] row_cells;
	logic                last_row;

	modport source (output valid, output row_cells, output last_row, input ready);
	modport sink   (input valid, input row_cells, input last_row, output ready);

endinterface

interface lgrs_out_if;
	import lgrs_pkg::*;

	logic                valid;
	logic                ready;
	logic [MAX_COLS-1:0] next_row_cells;
	logic                last_row_res;

	modport source (output valid, output next_row_cells, output last_row_res, input ready);
	modport sink   (input valid, input next_row_cells, input last_row_res, output ready);

endinterface

>>> sv/life_generation_row_stream.sv
// channel    dir  payload                        role
// cur_row    in   row_cells[63:0], last_row      one grid row per word, top row first
// next_row   out  next_row_cells[63:0], last_row_res  next generation, one row per word
// apb        in   cols_in_use at byte address 0  column count, higher columns dead
//
// a word is taken every cycle while the output side keeps draining
// a word that closes a grid after earlier rows yields two result words, which holds
//   the input back while the first one leaves; output rate is one word per cycle while ready is high
// results pass through the pending stage, then the output register
// arst_n clears the row cells, the pending stage and the output register
// a stalled output fills the pending stage, then drops cur_row.ready
module life_generation_row_stream
	import lgrs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	lgrs_in_if.sink           cur_row,
	lgrs_out_if.source        next_row,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	logic [COL_W-1:0]    cols_q;
	logic                mid_v_q;
	logic                acc;
	logic                take;
	logic [MAX_COLS-1:0] mask;
	logic [MAX_COLS-1:0] row_m;
	logic [MAX_COLS-1:0] gen0;
	logic [MAX_COLS-1:0] gen1;
	logic [MAX_COLS-1:0] mids;
	col_t                nb   [MAX_COLS];
	ctrl_t               ctrl;
	load_t               ld;
	reg_idx_t            ridx;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign ridx   = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COLS_RESET;
		end else if (psel && penable && pwrite && ridx == REG_COLS_IN_USE) begin
			cols_q <= pwdata[COL_W-1:0];
		end
	end

	always_comb begin
		unique case (ridx)
			REG_COLS_IN_USE: prdata = {{(DATA_W-COL_W){1'b0}}, cols_q};
			default:         prdata = '0;
		endcase
	end

	// ---------------- input handshake ----------------
	assign cur_row.ready = take;
	assign acc           = cur_row.valid && take;

	// middle row present: every word after the first of a grid has an upper neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_v_q <= 1'b0;
		end else if (acc) begin
			mid_v_q <= !cur_row.last_row;
		end
	end

	assign ctrl = '{shift: acc, clear: cur_row.last_row};

	// ---------------- row of column cells ----------------
	for (genvar k = 0; k < MAX_COLS; k++) begin : g_col
		col_t lft;
		col_t rgt;

		// column k lives while k is below the column count; counts past the top saturate
		assign mask[k]  = cols_q > COL_W'(k);
		assign row_m[k] = cur_row.row_cells[k] & mask[k];
		assign mids[k]  = nb[k].mid;

		if (k == 0) begin : g_lo
			assign lft = '0;
		end else begin : g_lo
			assign lft = nb[k-1];
		end

		if (k == MAX_COLS-1) begin : g_hi
			assign rgt = '0;
		end else begin : g_hi
			assign rgt = nb[k+1];
		end

		lgrs_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.mask   (mask[k]),
			.in_bit (row_m[k]),
			.left   (lft),
			.right  (rgt),
			.nb     (nb[k]),
			.gen0   (gen0[k]),
			.gen1   (gen1[k])
		);
	end

	// ---------------- result staging ----------------
	// first result: middle row against the new row; second: closing row of the grid
	// (a single-row grid has an empty middle, so the second slot covers it too)
	assign ld = '{load: acc, v0: mid_v_q, v1: cur_row.last_row};

	lgrs_obuf u_obuf (
		.clk    (clk),
		.arst_n (arst_n),
		.ld     (ld),
		.gen0   (gen0),
		.gen1   (gen1),
		.take   (take),
		.res    (next_row)
	);

`ifndef ASSERT_OFF
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && cur_row.last_row) |=> (!mid_v_q && mids == '0))
		else $error("grid end left a stored row behind");

	a_empty_middle: assert property (@(posedge clk) disable iff (!arst_n)
		!mid_v_q |-> (mids == '0))
		else $error("middle row cells hold data without a valid row");

	a_dead_cols: assert property (@(posedge clk) disable iff (!arst_n)
		next_row.valid |-> ((next_row.next_row_cells & ~mask) == '0))
		else $error("live cell in a dead column");

	a_row_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !cur_row.last_row) |=> mid_v_q)
		else $error("row not kept as middle row");
`endif

endmodule

>>> sv/lgrs_cell.sv
module lgrs_cell
	import lgrs_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  ctrl_t ctrl,
	input  logic  mask,
	input  logic  in_bit,
	input  col_t  left,
	input  col_t  right,
	output col_t  nb,
	output logic  gen0,
	output logic  gen1
);

	logic above_q;
	logic mid_q;

	// b3/s23 on a 3x3 window, center at bit 4
	function automatic logic life(input logic [8:0] win);
		logic [3:0] cnt;
		cnt = {3'b0, win[0]} + {3'b0, win[1]} + {3'b0, win[2]} + {3'b0, win[3]}
			+ {3'b0, win[5]} + {3'b0, win[6]} + {3'b0, win[7]} + {3'b0, win[8]};
		return (cnt == 4'd3) || (win[4] && (cnt == 4'd2));
	endfunction

	assign nb = '{up: above_q, mid: mid_q, dn: in_bit};

	always_comb begin
		// middle row against the incoming row below it
		gen0 = mask & life({left.up, above_q, right.up,
			left.mid, mid_q, right.mid,
			left.dn, in_bit, right.dn});
		// incoming row with a dead row below it
		gen1 = mask & life({left.mid, mid_q, right.mid,
			left.dn, in_bit, right.dn,
			3'b000});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			above_q <= 1'b0;
			mid_q   <= 1'b0;
		end else if (ctrl.shift) begin
			if (ctrl.clear) begin
				above_q <= 1'b0;
				mid_q   <= 1'b0;
			end else begin
				above_q <= mid_q;
				mid_q   <= in_bit;
			end
		end
	end

endmodule

>>> sv/lgrs_obuf.sv
module lgrs_obuf
	import lgrs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  load_t               ld,
	input  logic [MAX_COLS-1:0] gen0,
	input  logic [MAX_COLS-1:0] gen1,
	output logic                take,
	lgrs_out_if.source          res
);

	logic                p0_v_s1;
	logic                p1_v_s1;
	logic [MAX_COLS-1:0] p0_s1;
	logic [MAX_COLS-1:0] p1_s1;
	logic                o_v_q;
	logic [MAX_COLS-1:0] o_data_q;
	logic                o_last_q;
	logic                move;

	assign move = (p0_v_s1 || p1_v_s1) && (!o_v_q || res.ready);
	// room for a new word when nothing is pending or the only pending result is leaving now
	assign take = !(p0_v_s1 || p1_v_s1) || (move && !(p0_v_s1 && p1_v_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p0_v_s1 <= 1'b0;
			p1_v_s1 <= 1'b0;
		end else if (ld.load) begin
			p0_v_s1 <= ld.v0;
			p1_v_s1 <= ld.v1;
		end else if (move) begin
			if (p0_v_s1) begin
				p0_v_s1 <= 1'b0;
			end else begin
				p1_v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld.load) begin
			p0_s1 <= gen0;
			p1_s1 <= gen1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_q <= 1'b0;
		end else if (move) begin
			o_v_q <= 1'b1;
		end else if (res.ready) begin
			o_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			o_data_q <= p0_v_s1 ? p0_s1 : p1_s1;
			o_last_q <= !p0_v_s1;
		end
	end

	assign res.valid          = o_v_q;
	assign res.next_row_cells = o_data_q;
	assign res.last_row_res   = o_last_q;

endmodule

>>> tb/tb_life_generation_row_stream.sv
module tb_life_generation_row_stream;
	timeunit 1ns;
	timeprecision 1ps;

	import lgrs_pkg::*;

	// clock, run length and drain timing
	localparam real CLK_PERIOD   = 4.0;
	localparam int  RESET_CYCLES = 5;
	localparam int  DRAIN_CYCLES = 8;       // margin beyond the two-stage pipeline of pending stage and output register
	localparam int  RAND_WORDS   = 1100;
	localparam int  CALM_WORDS   = 150;     // tail of the run with no random idling on either side
	localparam int  CYCLE_LIMIT  = 400000;
	localparam int  NUM_DIR      = 23;

	localparam logic [MAX_COLS-1:0] ALL_ALIVE = '1;

	// one expected result word
	typedef struct packed {
		logic [MAX_COLS-1:0] cells;
		logic                last;
	} gen_row_t;

	// one row of the directed table; a nonzero n_fixed overrides the predictor
	typedef struct packed {
		logic                wr_cols;
		logic [COL_W-1:0]    cols;
		logic [MAX_COLS-1:0] cells;
		logic                last;
		logic [1:0]          n_fixed;
		logic [MAX_COLS-1:0] fixed0;
		logic [MAX_COLS-1:0] fixed1;
	} dir_step_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	lgrs_in_if  cur_row_if ();
	lgrs_out_if next_row_if ();

	life_generation_row_stream u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cur_row  (cur_row_if),
		.next_row (next_row_if),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #(CLK_PERIOD / 2.0) clk = ~clk;

	// shadow of the block: column count and the two held rows
	logic [COL_W-1:0]    pred_cols = COLS_RESET;
	logic [MAX_COLS-1:0] pred_above = '0;
	logic [MAX_COLS-1:0] pred_middle = '0;
	logic                pred_open = 1'b0;     // a grid is under way

	gen_row_t next_rows_due [$];
	int       mismatches = 0;
	int       cycle_count = 0;
	int       in_gap_pct = 0;
	int       out_gap_pct = 0;

	// directed words: edges of the width, the rule's corner cases and mask changes
	dir_step_t dir_steps [NUM_DIR] = '{
		// single-row grid at full width: the two end cells lack a second neighbor
		'{1'b0, 7'd0,   ALL_ALIVE, 1'b1, 2'd1, 64'h7FFF_FFFF_FFFF_FFFE, 64'h0},
		'{1'b0, 7'd0,   64'h0, 1'b1, 2'd1, 64'h0, 64'h0},
		// three full rows, middle row crowded out, ends included
		'{1'b0, 7'd0,   ALL_ALIVE, 1'b0, 2'd0, 64'h0, 64'h0},
		'{1'b0, 7'd0,   ALL_ALIVE, 1'b0, 2'd0, 64'h0, 64'h0},
		'{1'b0, 7'd0,   ALL_ALIVE, 1'b1, 2'd0, 64'h0, 64'h0},
		'{1'b0, 7'd0,   64'h8000_0000_0000_0001, 1'b0, 2'd0, 64'h0, 64'h0},
		'{1'b0, 7'd0,   64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 2'd0, 64'h0, 64'h0},
		'{1'b0, 7'd0,   64'h5555_5555_5555_5555, 1'b1, 2'd0, 64'h0, 64'h0},
		// no columns in use: everything dead
		'{1'b1, 7'd0,   ALL_ALIVE, 1'b0, 2'd0, 64'h0, 64'h0},
		'{1'b0, 7'd0,   ALL_ALIVE, 1'b1, 2'd2, 64'h0, 64'h0},
		// one column: a lone cell dies
		'{1'b1, 7'd1,   ALL_ALIVE, 1'b1, 2'd1, 64'h0, 64'h0},
		// counts past the width saturate
		'{1'b1, 7'd127, ALL_ALIVE, 1'b1, 2'd1, 64'h7FFF_FFFF_FFFF_FFFE, 64'h0},
		'{1'b1, 7'd65,  64'h8000_0000_0000_0000, 1'b1, 2'd1, 64'h0, 64'h0},
		// vertical blinker on a three-wide grid turns horizontal
		'{1'b1, 7'd3,   64'h2, 1'b0, 2'd0, 64'h0, 64'h0},
		'{1'b0, 7'd0,   64'h2, 1'b0, 2'd1, 64'h0, 64'h0},
		'{1'b0, 7'd0,   64'h2, 1'b1, 2'd2, 64'h7, 64'h0},
		// width changes while rows are held
		'{1'b1, 7'd63,  ALL_ALIVE, 1'b0, 2'd0, 64'h0, 64'h0},
		'{1'b1, 7'd8,   ALL_ALIVE, 1'b0, 2'd0, 64'h0, 64'h0},
		'{1'b0, 7'd0,   ALL_ALIVE, 1'b1, 2'd0, 64'h0, 64'h0},
		'{1'b1, 7'd64,  64'h0F0F_3C3C_F0F0_C3C3, 1'b0, 2'd0, 64'h0, 64'h0},
		'{1'b0, 7'd0,   64'hFFFF_0000_FFFF_0000, 1'b0, 2'd0, 64'h0, 64'h0},
		'{1'b0, 7'd0,   64'h0000_0001_8000_0000, 1'b1, 2'd0, 64'h0, 64'h0},
		'{1'b0, 7'd0,   64'hE000_0000_0000_0007, 1'b1, 2'd0, 64'h0, 64'h0}
	};

	task automatic report_mismatch(input string what, input logic [MAX_COLS-1:0] got,
			input logic [MAX_COLS-1:0] want);
		$display("%0t ns: %s got %h want %h", $realtime, what, got, want);
		mismatches++;
	endtask

	// live columns for a given count, saturating at the grid width
	function automatic logic [MAX_COLS-1:0] col_mask(input logic [COL_W-1:0] cols);
		int n;
		n = (int'(cols) > MAX_COLS) ? MAX_COLS : int'(cols);
		if (n == 0)
			return '0;
		return ALL_ALIVE >> (MAX_COLS - n);
	endfunction

	// b3/s23 on one row, dead beyond both side edges
	function automatic logic [MAX_COLS-1:0] life_rule(input logic [MAX_COLS-1:0] up,
			input logic [MAX_COLS-1:0] mid, input logic [MAX_COLS-1:0] dn,
			input logic [MAX_COLS-1:0] mask);
		logic [MAX_COLS-1:0] res;
		int                  k;
		int                  cnt;
		res = '0;
		for (k = 0; k < MAX_COLS; k++) begin
			cnt = int'(up[k]) + int'(dn[k]);
			if (k > 0)
				cnt += int'(up[k-1]) + int'(mid[k-1]) + int'(dn[k-1]);
			if (k < MAX_COLS - 1)
				cnt += int'(up[k+1]) + int'(mid[k+1]) + int'(dn[k+1]);
			res[k] = (cnt == 3) || (mid[k] && cnt == 2);
		end
		return res & mask;
	endfunction

	// rows of the next generation released by one accepted word
	task automatic advance_generation(input logic [MAX_COLS-1:0] cells, input logic last,
			output gen_row_t res [2], output int n);
		logic [MAX_COLS-1:0] mask;
		logic [MAX_COLS-1:0] row;
		mask = col_mask(pred_cols);
		row  = cells & mask;
		n    = 0;
		if (pred_open) begin
			res[0] = '{life_rule(pred_above, pred_middle, row, mask), 1'b0};
			n = 1;
			if (last) begin
				res[1] = '{life_rule(pred_middle, row, '0, mask), 1'b1};
				n = 2;
			end
		end else if (last) begin
			res[0] = '{life_rule('0, row, '0, mask), 1'b1};
			n = 1;
		end
		// closing word returns to the empty state
		if (last) begin
			pred_above  = '0;
			pred_middle = '0;
			pred_open   = 1'b0;
		end else begin
			pred_above  = pred_open ? pred_middle : '0;
			pred_middle = row;
			pred_open   = 1'b1;
		end
	endtask

	// starts and ends at a falling edge; leaves valid high for a following word
	task automatic send_row(input logic [MAX_COLS-1:0] cells, input logic last,
			input logic [1:0] n_fixed, input logic [MAX_COLS-1:0] fixed0,
			input logic [MAX_COLS-1:0] fixed1);
		gen_row_t res [2];
		int       n;
		int       i;
		if ($urandom_range(0, 99) < in_gap_pct) begin
			cur_row_if.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		cur_row_if.valid     <= 1'b1;
		cur_row_if.row_cells <= cells;
		cur_row_if.last_row  <= last;
		@(posedge clk);
		while (!cur_row_if.ready)
			@(posedge clk);
		advance_generation(cells, last, res, n);
		// hand-computed rows stand in for the predictor's
		if (n_fixed != 2'd0) begin
			n = int'(n_fixed);
			res[0] = '{fixed0, last && n == 1};
			res[1] = '{fixed1, last};
		end
		for (i = 0; i < n; i++)
			next_rows_due.push_back(res[i]);
		@(negedge clk);
	endtask

	// input quiet, every result back, then a margin for words still in flight
	task automatic settle_block();
		cur_row_if.valid <= 1'b0;
		while (next_rows_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// one apb transfer: setup cycle, then access until pready
	task automatic apb_access(input logic wr, input reg_idx_t idx,
			input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= ADDR_W'(4 * int'(idx));
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// write the column count while idle and read it back
	task automatic set_cols(input logic [COL_W-1:0] cols);
		logic [DATA_W-1:0] rd;
		settle_block();
		apb_access(1'b1, REG_COLS_IN_USE, DATA_W'(cols), rd);
		pred_cols = cols;
		// psel drops between the two transfers
		@(negedge clk);
		apb_access(1'b0, REG_COLS_IN_USE, '0, rd);
		if (rd !== DATA_W'(cols))
			report_mismatch("cols_in_use readback", MAX_COLS'(rd), MAX_COLS'(cols));
	endtask

	// in-range counts for four draws in ten, the rest count extremes and narrow grids
	function automatic logic [COL_W-1:0] pick_cols();
		case ($urandom_range(0, 9))
			0: return 7'd0;
			1: return COL_W'($urandom_range(MAX_COLS + 1, 127));
			2: return 7'd127;
			3: return COL_W'(MAX_COLS);
			4: return 7'd1;
			5: return COL_W'($urandom_range(1, 4));
			default: return COL_W'($urandom_range(1, MAX_COLS));
		endcase
	endfunction

	// row contents of varied density so births, deaths and survivals all show up
	function automatic logic [MAX_COLS-1:0] pick_row();
		logic [MAX_COLS-1:0] a;
		logic [MAX_COLS-1:0] b;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0, 1: return a & b;
			2:    return a | b;
			3:    return a & b & {$urandom, $urandom};
			4:    return MAX_COLS'(3'b111) << $urandom_range(0, MAX_COLS - 3);
			5:    return ($urandom_range(0, 1) != 0) ? ALL_ALIVE : '0;
			default: return a;
		endcase
	endfunction

	// output side: ready drops in random bursts
	initial begin
		int stall_left;
		stall_left = 0;
		next_row_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				next_row_if.ready <= 1'b0;
				stall_left--;
			end else if ($urandom_range(0, 99) < out_gap_pct) begin
				next_row_if.ready <= 1'b0;
				stall_left = $urandom_range(1, 6) - 1;
			end else begin
				next_row_if.ready <= 1'b1;
			end
		end
	end

	// result checker: every word taken must match the oldest expected row
	always @(posedge clk) begin
		gen_row_t want;
		if (arst_n && next_row_if.valid && next_row_if.ready) begin
			if (next_rows_due.size() == 0) begin
				report_mismatch("unexpected word", next_row_if.next_row_cells, '0);
			end else begin
				want = next_rows_due.pop_front();
				if (next_row_if.next_row_cells !== want.cells)
					report_mismatch("next_row_cells", next_row_if.next_row_cells, want.cells);
				if (next_row_if.last_row_res !== want.last)
					report_mismatch("last_row_res", MAX_COLS'(next_row_if.last_row_res),
						MAX_COLS'(want.last));
			end
		end
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// stimulus
	initial begin
		logic [DATA_W-1:0] rd;
		dir_step_t         st;
		int                i;
		int                words;
		int                height;
		int                chunk;

		cur_row_if.valid     = 1'b0;
		cur_row_if.row_cells = '0;
		cur_row_if.last_row  = 1'b0;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// column count comes out of reset at full width
		apb_access(1'b0, REG_COLS_IN_USE, '0, rd);
		if (rd !== DATA_W'(COLS_RESET))
			report_mismatch("cols_in_use after reset", MAX_COLS'(rd), MAX_COLS'(COLS_RESET));

		// directed table, light idling on both sides
		in_gap_pct  = 20;
		out_gap_pct = 20;
		for (i = 0; i < NUM_DIR; i++) begin
			st = dir_steps[i];
			if (st.wr_cols)
				set_cols(st.cols);
			send_row(st.cells, st.last, st.n_fixed, st.fixed0, st.fixed1);
		end

		// random grids: mostly short, a few tall, some single rows
		words = 0;
		chunk = -1;
		while (words < RAND_WORDS) begin
			// new idling mix every hundred words, none in the tail
			if (words >= RAND_WORDS - CALM_WORDS) begin
				in_gap_pct  = 0;
				out_gap_pct = 0;
			end else if (words / 100 != chunk) begin
				chunk       = words / 100;
				in_gap_pct  = (chunk % 4 == 3) ? 0 : $urandom_range(0, 50);
				out_gap_pct = (chunk % 4 == 1) ? 0 : $urandom_range(0, 50);
			end
			if ($urandom_range(0, 5) == 0)
				set_cols(pick_cols());
			case ($urandom_range(0, 9))
				0: height = 1;
				1: height = $urandom_range(10, 24);
				default: height = $urandom_range(2, 8);
			endcase
			for (i = 0; i < height; i++) begin
				// occasional width change with rows held in the block
				if (i > 0 && $urandom_range(0, 39) == 0)
					set_cols(pick_cols());
				send_row(pick_row(), i == height - 1, 2'd0, '0, '0);
				words++;
			end
		end

		// drain and let any stray word show up
		settle_block();
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
